>>> design/bitmap_text_glyph_placer_core_macros.svh
// assertion macros for the glyph placer checker
// expects clk and rst_n in the scope where a macro is used
`ifndef BITMAP_TEXT_GLYPH_PLACER_CORE_MACROS_SVH
`define BITMAP_TEXT_GLYPH_PLACER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define BTGP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define BTGP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/btgp_pkg.sv
// types and constants shared by the glyph placer modules
// no dependencies
package btgp_pkg;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_CHAR  = 2'd2;

    localparam logic [1:0] KIND_DRAW  = 2'd0;
    localparam logic [1:0] KIND_ENDED = 2'd1;
    localparam logic [1:0] KIND_CUT   = 2'd2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_CODE       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LAST_CODE        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_HEIGHT      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_LIMIT      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_TO_LEFT    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_STOP_ON_OVERFLOW = 3'd5;

    localparam logic [7:0]         FIRST_CODE_RESET  = 8'd32;
    localparam logic [7:0]         LAST_CODE_RESET   = 8'd255;
    localparam logic [7:0]         LINE_HEIGHT_RESET = 8'd16;
    localparam logic signed [15:0] RIGHT_LIMIT_RESET = 16'sd3000;

    typedef struct packed {
        logic [1:0]         operation;
        logic [7:0]         char_code;
        logic [11:0]        src_x;
        logic [11:0]        src_y;
        logic [7:0]         glyph_width;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [11:0]        rect_left;
        logic [11:0]        rect_top;
        logic [7:0]         rect_width;
        logic signed [15:0] dest_x;
        logic signed [15:0] dest_y;
    } out_item_t;

    typedef struct packed {
        logic [11:0] left;
        logic [11:0] top;
        logic [7:0]  width;
    } glyph_t;

    typedef struct packed {
        logic [7:0]         first_code;
        logic [7:0]         last_code;
        logic [7:0]         line_height;
        logic signed [15:0] right_limit;
        logic               right_to_left;
        logic               stop_on_overflow;
    } cfg_t;

    // request held in the pen stage
    typedef struct packed {
        logic               valid;
        logic [1:0]         op;
        logic [7:0]         code;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } pen_req_t;

    typedef struct packed {
        logic      has_result;
        out_item_t item;
    } pen_rsp_t;

endpackage

>>> design/btgp_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module btgp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds while no read is issued
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/btgp_pen.sv
// pen stage: holds pen, line start and string state, decides each result
// depends on btgp_pkg
module btgp_pen #(
    parameter int NUM_CODES  = 256,
    parameter int COORD_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  btgp_pkg::pen_req_t req,
    input  btgp_pkg::glyph_t  entry,
    input  btgp_pkg::cfg_t    cfg,
    input  logic              commit,
    output btgp_pkg::pen_rsp_t rsp
);

    localparam int CW    = COORD_BITS;
    localparam int CMP_W = ((CW > 16) ? CW : 16) + 2;

    logic [CW-1:0] pen_x_reg, pen_x_next;
    logic [CW-1:0] pen_y_reg, pen_y_next;
    logic [CW-1:0] line_x_reg, line_x_next;
    logic          halted_reg, halted_next;

    logic                    code_ok;
    logic                    in_table;
    logic                    draw_ok;
    logic [CW-1:0]           w_ext;
    logic [CW-1:0]           x_pre;
    logic signed [CMP_W-1:0] reach;
    logic signed [CMP_W-1:0] limit;
    logic                    over;
    logic [CW-1:0]           x_draw;
    logic [CW-1:0]           y_draw;

    assign code_ok  = req.code >= cfg.first_code;
    assign in_table = {1'b0, req.code} < 9'(NUM_CODES);
    assign draw_ok  = (req.code <= cfg.last_code) && in_table;
    assign w_ext    = CW'(entry.width);

    // right-to-left steps back before the glyph
    assign x_pre = cfg.right_to_left ? (pen_x_reg - w_ext) : pen_x_reg;

    // limit compare without wrap
    assign reach = CMP_W'($signed(x_pre)) + CMP_W'($signed({1'b0, entry.width}));
    assign limit = CMP_W'(cfg.right_limit);
    assign over  = reach > limit;

    assign x_draw = over ? line_x_reg : x_pre;
    assign y_draw = over ? (pen_y_reg + CW'(cfg.line_height)) : pen_y_reg;

    always_comb
    begin
        pen_x_next  = pen_x_reg;
        pen_y_next  = pen_y_reg;
        line_x_next = line_x_reg;
        halted_next = halted_reg;
        rsp         = '0;
        if (req.valid)
        begin
            case (req.op)
                btgp_pkg::OP_START:
                begin
                    pen_x_next  = CW'(req.pos_x);
                    pen_y_next  = CW'(req.pos_y);
                    line_x_next = CW'(req.pos_x);
                    halted_next = 1'b0;
                end
                btgp_pkg::OP_CHAR:
                begin
                    if (!halted_reg)
                    begin
                        if (!code_ok)
                        begin
                            rsp.has_result  = 1'b1;
                            rsp.item.kind   = btgp_pkg::KIND_ENDED;
                            rsp.item.dest_x = 16'(pen_x_reg);
                            rsp.item.dest_y = 16'(pen_y_reg);
                            halted_next     = 1'b1;
                        end
                        else if (draw_ok)
                        begin
                            rsp.has_result = 1'b1;
                            if (over && cfg.stop_on_overflow)
                            begin
                                rsp.item.kind   = btgp_pkg::KIND_CUT;
                                rsp.item.dest_x = 16'(x_pre);
                                rsp.item.dest_y = 16'(pen_y_reg);
                                pen_x_next      = x_pre;
                                halted_next     = 1'b1;
                            end
                            else
                            begin
                                rsp.item.kind       = btgp_pkg::KIND_DRAW;
                                rsp.item.rect_left  = entry.left;
                                rsp.item.rect_top   = entry.top;
                                rsp.item.rect_width = entry.width;
                                rsp.item.dest_x     = 16'(x_draw);
                                rsp.item.dest_y     = 16'(y_draw);
                                pen_x_next = cfg.right_to_left ? x_draw : (x_draw + w_ext);
                                pen_y_next = y_draw;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg  <= '0;
            pen_y_reg  <= '0;
            line_x_reg <= '0;
            halted_reg <= 1'b1;
        end
        else if (commit)
        begin
            pen_x_reg  <= pen_x_next;
            pen_y_reg  <= pen_y_next;
            line_x_reg <= line_x_next;
            halted_reg <= halted_next;
        end
    end

endmodule

>>> design/bitmap_text_glyph_placer_core.sv
// top level of the bitmap font glyph placer: glyph table ram, pen stage, result register
// depends on btgp_pkg, btgp_ram, btgp_pen
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  btgp_pkg::in_item_t
//  rsp      out        rsp_valid / rsp_stall  btgp_pkg::out_item_t
//  cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one request per cycle while req_stall is low; a result is registered in rsp_data
// the glyph table ram read and s1_reg come first, then the pen compare and update
// loads write the table in the cycle they are taken, so a following character sees them
// req_stall rises only while the result register is full and rsp_stall holds it
// reset clears pen, string state and valid flags; the table and rsp_data are not cleared
// cfg_ready is always high
module bitmap_text_glyph_placer_core #(
    parameter int NUM_CODES  = 256,
    parameter int COORD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  btgp_pkg::in_item_t                  req_data,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output btgp_pkg::out_item_t                 rsp_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [btgp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [btgp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = $clog2(NUM_CODES);

    btgp_pkg::cfg_t     cfg_reg;
    btgp_pkg::pen_req_t s1_reg, s1_next;
    btgp_pkg::pen_rsp_t pen_rsp;
    btgp_pkg::glyph_t   wr_entry;
    btgp_pkg::glyph_t   rd_entry;
    btgp_pkg::out_item_t rsp_data_reg;
    logic                rsp_valid_reg, rsp_valid_next;

    logic accept;
    logic out_free;
    logic s1_adv;
    logic commit;
    logic load_ok;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_code       <= btgp_pkg::FIRST_CODE_RESET;
            cfg_reg.last_code        <= btgp_pkg::LAST_CODE_RESET;
            cfg_reg.line_height      <= btgp_pkg::LINE_HEIGHT_RESET;
            cfg_reg.right_limit      <= btgp_pkg::RIGHT_LIMIT_RESET;
            cfg_reg.right_to_left    <= 1'b0;
            cfg_reg.stop_on_overflow <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                btgp_pkg::CFG_FIRST_CODE:       cfg_reg.first_code       <= cfg_data[7:0];
                btgp_pkg::CFG_LAST_CODE:        cfg_reg.last_code        <= cfg_data[7:0];
                btgp_pkg::CFG_LINE_HEIGHT:      cfg_reg.line_height      <= cfg_data[7:0];
                btgp_pkg::CFG_RIGHT_LIMIT:      cfg_reg.right_limit      <= cfg_data;
                btgp_pkg::CFG_RIGHT_TO_LEFT:    cfg_reg.right_to_left    <= cfg_data[0];
                btgp_pkg::CFG_STOP_ON_OVERFLOW: cfg_reg.stop_on_overflow <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // handshake and stage advance
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign s1_adv    = !pen_rsp.has_result || out_free;
    assign commit    = s1_reg.valid && s1_adv;
    assign req_stall = s1_reg.valid && !s1_adv;
    assign accept    = req_valid && !req_stall;

    // glyph table
    assign load_ok  = accept && (req_data.operation == btgp_pkg::OP_LOAD)
                      && ({1'b0, req_data.char_code} < 9'(NUM_CODES));
    assign wr_entry = '{left: req_data.src_x, top: req_data.src_y,
                        width: req_data.glyph_width};

    btgp_ram #(
        .WIDTH ($bits(btgp_pkg::glyph_t)),
        .DEPTH (NUM_CODES)
    ) u_table (
        .clk     (clk),
        .wr_en   (load_ok),
        .wr_addr (req_data.char_code[AW-1:0]),
        .wr_data (wr_entry),
        .rd_en   (accept && (req_data.operation == btgp_pkg::OP_CHAR)),
        .rd_addr (req_data.char_code[AW-1:0]),
        .rd_data (rd_entry)
    );

    always_comb
    begin
        s1_next = s1_reg;
        if (accept)
        begin
            s1_next.valid = 1'b1;
            s1_next.op    = req_data.operation;
            s1_next.code  = req_data.char_code;
            s1_next.pos_x = req_data.pos_x;
            s1_next.pos_y = req_data.pos_y;
        end
        else if (s1_adv)
        begin
            s1_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
        end
    end

    btgp_pen #(
        .NUM_CODES  (NUM_CODES),
        .COORD_BITS (COORD_BITS)
    ) u_pen (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (s1_reg),
        .entry  (rd_entry),
        .cfg    (cfg_reg),
        .commit (commit),
        .rsp    (pen_rsp)
    );

    // result register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (commit && pen_rsp.has_result)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && pen_rsp.has_result)
        begin
            rsp_data_reg <= pen_rsp.item;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

>>> design/btgp_checker.sv
// port-level checks for the glyph placer, bound to the top level
// depends on btgp_pkg and bitmap_text_glyph_placer_core_macros.svh
`include "bitmap_text_glyph_placer_core_macros.svh"

module btgp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_stall,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input btgp_pkg::out_item_t rsp_data
);

    logic req_take;
    logic rsp_held;
    logic rsp_no_draw;
    logic rect_zero;

    assign req_take    = req_valid && !req_stall;
    assign rsp_held    = rsp_valid && rsp_stall;
    assign rsp_no_draw = rsp_valid && (rsp_data.kind != btgp_pkg::KIND_DRAW);
    assign rect_zero   = (rsp_data.rect_left == 12'd0) && (rsp_data.rect_top == 12'd0)
                         && (rsp_data.rect_width == 8'd0);

    // a held result keeps its payload
    `BTGP_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_data), "held rsp changed")

    // requests are only held back by a full, stalled result register
    `BTGP_ASSERT_NOW(a_stall_cause, req_stall, rsp_held, "req stalled without backpressure")

    // end and cut results carry no source rectangle
    `BTGP_ASSERT_NOW(a_rect_zero, rsp_no_draw, rect_zero, "rect set on end or cut")

    // a fresh result comes from a request that was taken and then held in the pen stage register
    `BTGP_ASSERT_NOW(a_rsp_source, $rose(rsp_valid), $past(req_take, 2), "result without request")

endmodule

bind bitmap_text_glyph_placer_core btgp_checker u_checker (.*);
